// ===== rtl/lzss_window_decompressor_macros.svh =====
// assertion helpers for the decompressor control module
`ifndef LZSS_WINDOW_DECOMPRESSOR_MACROS_SVH
`define LZSS_WINDOW_DECOMPRESSOR_MACROS_SVH

// property checked on every clock edge outside reset
`define LZWD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define LZWD_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/lzwd_pkg.sv =====
`timescale 1ns / 1ps

package lzwd_pkg;

	localparam int RING_SIZE  = 4096;
	localparam int RING_AW    = $clog2(RING_SIZE);
	localparam int MAX_MATCH  = 18;
	localparam int MIN_MATCH  = 3;
	localparam int RING_START = RING_SIZE - MAX_MATCH;
	localparam int FLAG_BITS  = 8;
	localparam int SKIP_W     = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int RUN_W      = $clog2(MAX_MATCH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LEADING_SKIP = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		PH_START,
		PH_SKIP,
		PH_HEADER,
		PH_FLAG,
		PH_TOKEN,
		PH_MATCHHI,
		PH_DONE,
		PH_REFUSED
	} phase_t;

	typedef enum logic {
		KIND_DATA,
		KIND_REPORT
	} kind_t;

	typedef enum logic [1:0] {
		ST_COMPLETE,
		ST_TRUNCATED,
		ST_REFUSED
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [7:0]  data_byte;
		logic [31:0] bytes_written;
		status_t     status;
		logic        run_last;
	} out_item_t;

	typedef struct packed {
		logic               wr_en;
		logic [7:0]         wr_data;
		logic               rd_en;
		logic [RING_AW-1:0] rd_addr;
		logic               clear;
		logic               rewind;
	} win_cmd_t;

endpackage

// ===== rtl/lzwd_window.sv =====
`timescale 1ns / 1ps

module lzwd_window (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lzwd_pkg::win_cmd_t      cmd,
	output logic [7:0]              rd_byte
);

	localparam int AW = lzwd_pkg::RING_AW;
	localparam logic [AW-1:0] START_POS = AW'(lzwd_pkg::RING_START);
	localparam logic [AW:0]   FULL      = (AW + 1)'(lzwd_pkg::RING_SIZE);

	logic [7:0]    mem [lzwd_pkg::RING_SIZE];
	logic [AW-1:0] wpos_q;
	logic [AW:0]   fill_q;
	logic [7:0]    rd_q;
	logic          valid_s1;
	logic          fwd_s1;
	logic [7:0]    fwd_data_s1;
	logic [AW-1:0] rel;

	// writes run in order from the start position, so a fill count tells
	// which entries hold data since the last clear
	assign rel = cmd.rd_addr - START_POS;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wpos_q] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q   <= START_POS;
			fill_q   <= '0;
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (cmd.rewind) begin
				wpos_q <= START_POS;
			end else if (cmd.wr_en) begin
				wpos_q <= wpos_q + AW'(1);
			end
			if (cmd.clear) begin
				fill_q <= '0;
			end else if (cmd.wr_en && fill_q != FULL) begin
				fill_q <= fill_q + (AW + 1)'(1);
			end
			if (cmd.rd_en) begin
				valid_s1 <= {1'b0, rel} < fill_q;
				// same-cycle write to the entry being read
				fwd_s1   <= cmd.wr_en && (cmd.rd_addr == wpos_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			fwd_data_s1 <= cmd.wr_data;
		end
	end

	assign rd_byte = fwd_s1 ? fwd_data_s1 : (valid_s1 ? rd_q : 8'd0);

endmodule

// ===== rtl/lzwd_ctrl.sv =====
`timescale 1ns / 1ps
`include "lzss_window_decompressor_macros.svh"

module lzwd_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  lzwd_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lzwd_pkg::out_item_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lzwd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lzwd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output lzwd_pkg::win_cmd_t                  win_cmd,
	input  logic [7:0]                          win_rd_byte
);

	localparam int AW = lzwd_pkg::RING_AW;
	localparam int SW = lzwd_pkg::SKIP_W;
	localparam int RW = lzwd_pkg::RUN_W;

	lzwd_pkg::phase_t    phase_q, phase_d, ph_e;
	logic [SW-1:0]       skip_q, skip_e;
	logic [1:0]          hidx_q;
	logic [31:0]         target_q;
	logic [7:0]          flag_q;
	logic [3:0]          flags_left_q;
	logic [7:0]          match_low_q;
	logic [31:0]         out_count_q;
	logic                run_q;
	logic                rpt_q;
	logic [RW-1:0]       rem_q;
	logic [AW-1:0]       raddr_q;
	logic [31:0]         cap_q;
	logic [SW-1:0]       lskip_q;
	logic                out_valid_q;
	lzwd_pkg::out_item_t out_q, out_d;

	logic          in_fire, cfg_fire, free;
	logic [7:0]    b;
	logic          last;
	logic [31:0]   diff;
	logic [31:0]   hdr_size;
	logic          size_bad;
	logic          lit;
	logic [RW-1:0] len;
	logic [RW-1:0] run_cnt;
	logic          hdr_done;
	logic          lit_emit, match_start, run_emit, rpt_fire, data_emit, out_load;
	logic [7:0]    emit_byte;
	logic [AW-1:0] off;

	assign b        = in_data.in_byte;
	assign last     = in_data.in_last;
	assign in_fire  = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign free     = !out_valid_q || out_ready;

	// phase the current beat sees once skip loading and an empty skip are applied
	always_comb begin
		ph_e   = phase_q;
		skip_e = skip_q;
		if (phase_q == lzwd_pkg::PH_START) begin
			ph_e   = lzwd_pkg::PH_SKIP;
			skip_e = lskip_q;
		end
		if (ph_e == lzwd_pkg::PH_SKIP && skip_e == '0) begin
			ph_e = lzwd_pkg::PH_HEADER;
		end
	end

	assign diff     = target_q - out_count_q;
	assign hdr_size = target_q | ({24'd0, b} << {hidx_q, 3'b000});
	assign size_bad = (hdr_size == 32'd0) || (hdr_size > cap_q);
	assign hdr_done = hidx_q == 2'd3;
	assign lit      = flag_q[0];
	assign len      = RW'(b[3:0]) + RW'(lzwd_pkg::MIN_MATCH);
	assign run_cnt  = (diff < 32'(len)) ? diff[RW-1:0] : len;
	assign off      = AW'({b[7:4], match_low_q});

	// next state
	always_comb begin
		phase_d = phase_q;
		if (rpt_fire) begin
			phase_d = lzwd_pkg::PH_START;
		end else if (in_fire) begin
			unique case (ph_e)
				lzwd_pkg::PH_SKIP: begin
					phase_d = (skip_e == SW'(1)) ? lzwd_pkg::PH_HEADER : lzwd_pkg::PH_SKIP;
				end
				lzwd_pkg::PH_HEADER: begin
					if (hdr_done) begin
						phase_d = size_bad ? lzwd_pkg::PH_REFUSED : lzwd_pkg::PH_FLAG;
					end else begin
						phase_d = lzwd_pkg::PH_HEADER;
					end
				end
				lzwd_pkg::PH_FLAG: begin
					phase_d = lzwd_pkg::PH_TOKEN;
				end
				lzwd_pkg::PH_TOKEN: begin
					if (!lit) begin
						phase_d = lzwd_pkg::PH_MATCHHI;
					end else if (diff == 32'd1) begin
						phase_d = lzwd_pkg::PH_DONE;
					end else begin
						phase_d = (flags_left_q == 4'd1) ? lzwd_pkg::PH_FLAG
							: lzwd_pkg::PH_TOKEN;
					end
				end
				lzwd_pkg::PH_MATCHHI: begin
					if (diff <= 32'(len)) begin
						phase_d = lzwd_pkg::PH_DONE;
					end else begin
						phase_d = (flags_left_q == 4'd0) ? lzwd_pkg::PH_FLAG
							: lzwd_pkg::PH_TOKEN;
					end
				end
				default: begin
					phase_d = ph_e;
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		in_ready    = !run_q && !rpt_q && free;
		lit_emit    = in_fire && ph_e == lzwd_pkg::PH_TOKEN && lit;
		match_start = in_fire && ph_e == lzwd_pkg::PH_MATCHHI;
		run_emit    = run_q && free;
		rpt_fire    = rpt_q && !run_q && free;
		data_emit   = lit_emit || run_emit;
		out_load    = data_emit || rpt_fire;
		emit_byte   = lit_emit ? b : win_rd_byte;

		win_cmd.wr_en   = data_emit;
		win_cmd.wr_data = emit_byte;
		win_cmd.rd_en   = match_start || (run_emit && rem_q != RW'(1));
		win_cmd.rd_addr = match_start ? off : raddr_q + AW'(1);
		win_cmd.clear   = in_fire && ph_e == lzwd_pkg::PH_HEADER && hdr_done && !size_bad;
		win_cmd.rewind  = rpt_fire;

		out_d.result_kind   = lzwd_pkg::KIND_DATA;
		out_d.data_byte     = emit_byte;
		out_d.bytes_written = out_count_q + 32'd1;
		out_d.status        = lzwd_pkg::ST_COMPLETE;
		out_d.run_last      = lit_emit ? !last : (rem_q == RW'(1) && !rpt_q);
		if (rpt_fire) begin
			out_d.result_kind = lzwd_pkg::KIND_REPORT;
			out_d.data_byte   = 8'd0;
			out_d.run_last    = 1'b1;
			case (phase_q) inside
				lzwd_pkg::PH_START, lzwd_pkg::PH_SKIP, lzwd_pkg::PH_HEADER,
				lzwd_pkg::PH_REFUSED: begin
					out_d.bytes_written = 32'd0;
					out_d.status        = lzwd_pkg::ST_REFUSED;
				end
				default: begin
					out_d.bytes_written = out_count_q;
					out_d.status = (out_count_q >= target_q) ? lzwd_pkg::ST_COMPLETE
						: lzwd_pkg::ST_TRUNCATED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= '1;
			lskip_q <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				lzwd_pkg::REG_OUT_CAPACITY: cap_q   <= cfg_data;
				lzwd_pkg::REG_LEADING_SKIP: lskip_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= lzwd_pkg::PH_START;
			skip_q       <= '0;
			hidx_q       <= '0;
			target_q     <= '0;
			flag_q       <= '0;
			flags_left_q <= '0;
			match_low_q  <= '0;
			out_count_q  <= '0;
			run_q        <= 1'b0;
			rpt_q        <= 1'b0;
			rem_q        <= '0;
			raddr_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (rpt_fire) begin
				// fresh stream
				skip_q       <= '0;
				hidx_q       <= '0;
				target_q     <= '0;
				flag_q       <= '0;
				flags_left_q <= '0;
				match_low_q  <= '0;
				out_count_q  <= '0;
				rpt_q        <= 1'b0;
			end else begin
				if (data_emit) begin
					out_count_q <= out_count_q + 32'd1;
				end
				if (run_emit) begin
					rem_q   <= rem_q - RW'(1);
					raddr_q <= raddr_q + AW'(1);
					if (rem_q == RW'(1)) begin
						run_q <= 1'b0;
					end
				end
				if (in_fire) begin
					if (last) begin
						rpt_q <= 1'b1;
					end
					skip_q <= (ph_e == lzwd_pkg::PH_SKIP) ? skip_e - SW'(1) : skip_e;
					case (ph_e)
						lzwd_pkg::PH_HEADER: begin
							target_q <= hdr_size;
							hidx_q   <= hidx_q + 2'd1;
						end
						lzwd_pkg::PH_FLAG: begin
							flag_q       <= b;
							flags_left_q <= 4'(lzwd_pkg::FLAG_BITS);
						end
						lzwd_pkg::PH_TOKEN: begin
							flag_q       <= flag_q >> 1;
							flags_left_q <= flags_left_q - 4'd1;
							if (!lit) begin
								match_low_q <= b;
							end
						end
						lzwd_pkg::PH_MATCHHI: begin
							run_q   <= 1'b1;
							rem_q   <= run_cnt;
							raddr_q <= off;
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`LZWD_ASSERT(a_run_len, clk, arst_n, run_q |-> rem_q != '0, "match run with no bytes left")
	`LZWD_ASSERT(a_run_bound, clk, arst_n, run_q |-> out_count_q < target_q, "run past size")
	`LZWD_ASSERT(a_done_count, clk, arst_n, (phase_q == lzwd_pkg::PH_DONE && !run_q) |-> out_count_q == target_q, "done with wrong count")
	`LZWD_NEVER(a_no_overwrite, clk, arst_n, out_valid_q && !out_ready && out_load, "held result overwritten")

endmodule

// ===== rtl/lzss_window_decompressor.sv =====
`timescale 1ns / 1ps
// LZSS decompressor with a 4 KiB history ring.
// in channel: one compressed byte per beat, in_last marks the final byte of a
// stream. The first leading_skip bytes are dropped, four bytes give the
// little-endian output size, then flag bytes and tokens follow.
// out channel: one decoded byte per beat, and after the last input byte one
// end report (count and status). run_last flags the final result of an input.
// cfg channel: cfg_index 0 sets out_capacity, 1 sets leading_skip; always ready.
// Skip, header, flag and literal bytes are taken back to back while out
// can accept; a literal shows on out in the cycle after it is taken. A match
// token starts a run of 3 to 18 bytes, cut to the bytes still owed, that leave
// one per cycle while out can accept, paced by the single read port of the
// history memory (registered read with same-cycle write bypass).
// Reset empties the output register, restores the registers to capacity
// all ones and skip zero, and marks the whole history as zero without a sweep.
// When out_ready is low the pending result holds and decoding pauses; input
// is not taken until the output register can accept again.
module lzss_window_decompressor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  lzwd_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lzwd_pkg::out_item_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lzwd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lzwd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	lzwd_pkg::win_cmd_t win_cmd;
	logic [7:0]         win_rd_byte;

	lzwd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.win_cmd     (win_cmd),
		.win_rd_byte (win_rd_byte)
	);

	lzwd_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (win_cmd),
		.rd_byte (win_rd_byte)
	);

endmodule
